// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of the statistics block.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property sampled on the rising clock, switched off while reset is held.
`define RFS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("range_filtered_statistics: property failed");

// Same-cycle implication sampled on the rising clock, switched off while reset is held.
`define RFS_ASSERT_IMPLY(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("range_filtered_statistics: implication failed");

`endif

// ===== hw/rtl/rfs_pkg.sv =====
// Package for the range-filtered statistics block: widths, codes, state enum and structs.
// No dependencies; every RTL module of the block imports it.
`default_nettype none

package rfs_pkg;

    // Set size limit and derived accumulator widths.
    localparam int MAX_ITEMS   = 1024;
    localparam int VALUE_W     = 16;
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W       = VALUE_W + CNT_W;
    localparam int SQ_W        = 2 * VALUE_W + CNT_W;
    localparam int PROD1_W     = CNT_W + VALUE_W;
    localparam int DIFF_W      = SUM_W + 1;
    localparam int PROD2_W     = VALUE_W + DIFF_W;

    // Q.8 deviation: the variance is scaled by 2^16 before the root.
    localparam int FRAC_SHIFT  = 16;
    localparam int DVD_W       = SQ_W + FRAC_SHIFT;
    localparam int DIV_CNT_W   = $clog2(DVD_W + 1);
    localparam int ROOT_TOP    = ((DVD_W - 1) / 2) * 2;
    localparam int STD_W       = 24;

    // Job queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Configuration register map.
    localparam int CFG_IDX_W   = 1;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_LOWER_LIMIT = CFG_IDX_W'(0);
    localparam t_cfg_idx REG_UPPER_LIMIT = CFG_IDX_W'(1);

    localparam logic [VALUE_W-1:0] LOWER_RESET = VALUE_W'(10);
    localparam logic [VALUE_W-1:0] UPPER_RESET = VALUE_W'(500);
    localparam logic [VALUE_W-1:0] MIN_RESET   = {VALUE_W{1'b1}};
    localparam logic [STD_W-1:0]   STD_MAX     = {STD_W{1'b1}};

    // Accumulated totals of one closed set.
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [SUM_W-1:0]   sum;
        logic [SQ_W-1:0]    sq_sum;
        logic [VALUE_W-1:0] min;
        logic [VALUE_W-1:0] max;
        logic               overflowed;
    } t_job;

    // One finished result beat.
    typedef struct packed {
        logic [CNT_W-1:0]   valid_count;
        logic [VALUE_W-1:0] mean_value;
        logic [VALUE_W-1:0] min_value;
        logic [VALUE_W-1:0] max_value;
        logic [STD_W-1:0]   std_dev_q8;
        logic               no_valid;
        logic               overflowed;
    } t_result;

    // Divider request and response.
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

    // Back-end sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_MEAN,
        ST_WAIT_MEAN,
        ST_MUL1,
        ST_MUL2,
        ST_VAR,
        ST_DIV_VAR,
        ST_WAIT_VAR,
        ST_SQRT,
        ST_FINISH
    } t_back_state;

endpackage

`default_nettype wire

// ===== hw/rtl/rfs_front.sv =====
// Front end: window limits, per-beat filtering and running totals of the open set.
// Depends on rfs_pkg; hands each closed set to the job queue as a t_job.
`default_nettype none

module rfs_front
    import rfs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire t_cfg_idx           i_cfg_index,
    input  wire logic [VALUE_W-1:0] i_cfg_data,
    input  wire logic               i_accept,
    input  wire logic [VALUE_W-1:0] i_sample_value,
    input  wire logic               i_last_item,
    output logic                    o_job_push,
    output t_job                    o_job
);

    logic [VALUE_W-1:0] r_lower;
    logic [VALUE_W-1:0] r_upper;
    logic [CNT_W-1:0]   r_seen,  n_seen;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [SUM_W-1:0]   r_sum,   n_sum;
    logic [SQ_W-1:0]    r_sq,    n_sq;
    logic [VALUE_W-1:0] r_min,   n_min;
    logic [VALUE_W-1:0] r_max,   n_max;
    logic               r_ovf,   n_ovf;
    logic               in_window;
    logic               room;
    logic [2*VALUE_W-1:0] square;

    assign in_window = (i_sample_value >= r_lower) && (i_sample_value <= r_upper);
    assign room      = (r_seen < CNT_W'(MAX_ITEMS));
    assign square    = i_sample_value * i_sample_value;

    // Totals after the current beat is folded in.
    always_comb begin
        n_seen = r_seen;
        n_cnt  = r_cnt;
        n_sum  = r_sum;
        n_sq   = r_sq;
        n_min  = r_min;
        n_max  = r_max;
        n_ovf  = r_ovf;
        if (i_accept) begin
            if (!room) begin
                n_ovf = 1'b1;
            end else begin
                n_seen = r_seen + 1'b1;
                if (in_window) begin
                    n_cnt = r_cnt + 1'b1;
                    n_sum = r_sum + SUM_W'(i_sample_value);
                    n_sq  = r_sq + SQ_W'(square);
                    if (i_sample_value < r_min) begin
                        n_min = i_sample_value;
                    end
                    if (i_sample_value > r_max) begin
                        n_max = i_sample_value;
                    end
                end
            end
        end
    end

    // A last beat closes the set and pushes its totals.
    assign o_job_push       = i_accept && i_last_item;
    assign o_job.count      = n_cnt;
    assign o_job.sum        = n_sum;
    assign o_job.sq_sum     = n_sq;
    assign o_job.min        = n_min;
    assign o_job.max        = n_max;
    assign o_job.overflowed = n_ovf;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= LOWER_RESET;
            r_upper <= UPPER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LOWER_LIMIT: r_lower <= i_cfg_data;
                REG_UPPER_LIMIT: r_upper <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Running totals, cleared at reset and after each closed set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_item)) begin
            r_seen <= '0;
            r_cnt  <= '0;
            r_sum  <= '0;
            r_sq   <= '0;
            r_min  <= MIN_RESET;
            r_max  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_seen <= n_seen;
            r_cnt  <= n_cnt;
            r_sum  <= n_sum;
            r_sq   <= n_sq;
            r_min  <= n_min;
            r_max  <= n_max;
            r_ovf  <= n_ovf;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rfs_queue.sv =====
// Short job queue that decouples the front end from the back end.
// Depends on rfs_pkg for t_job and the queue depth.
`default_nettype none

module rfs_queue
    import rfs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_head,
    output logic      o_empty,
    output logic      o_full
);

    t_job               r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == Q_CNT_W'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rfs_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by the mean and variance steps.
// Depends on rfs_pkg for widths and the request and response structs.
`default_nettype none

module rfs_divider
    import rfs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic [DVD_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_divisor;
    logic [DIV_CNT_W-1:0] r_steps;
    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W:0]       shifted;
    logic                 fits;
    logic [CNT_W:0]       diff;

    // One trial subtraction per cycle.
    assign shifted = {r_rem, r_quo[DVD_W-1]};
    assign fits    = (shifted >= {1'b0, r_divisor});
    assign diff    = shifted - {1'b0, r_divisor};

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo     <= i_req.dividend;
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], fits};
            r_rem <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_steps <= DIV_CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_steps <= r_steps - 1'b1;
                if (r_steps == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rfs_back.sv =====
// Back end: sequencer for mean, variance, scaled division and square root of one set.
// Depends on rfs_pkg and rfs_divider; holds the output register of the block.
`default_nettype none

module rfs_back
    import rfs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire logic i_job_empty,
    output logic      o_job_pop,
    input  wire logic i_pop,
    output logic      o_result_valid,
    output t_result   o_result
);

    t_back_state          r_state, n_state;
    t_job                 r_job;
    logic [VALUE_W-1:0]   r_mean;
    logic [PROD1_W-1:0]   r_prod1;
    logic [PROD2_W-1:0]   r_prod2;
    logic [SQ_W-1:0]      r_var;
    logic [DVD_W-1:0]     r_sq_v;
    logic [DVD_W-1:0]     r_sq_res;
    logic [DVD_W-1:0]     r_sq_bit;
    logic                 r_out_valid;
    t_result              r_out;
    t_div_req             div_req;
    t_div_rsp             div_rsp;
    logic                 out_load;
    logic [DIFF_W-1:0]    diff;
    logic [DVD_W:0]       trial;
    logic                 trial_fits;
    logic                 no_valid;

    rfs_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign no_valid   = (r_job.count == '0);
    assign diff       = {r_job.sum, 1'b0} - DIFF_W'(r_prod1);
    assign trial      = {1'b0, r_sq_res} + {1'b0, r_sq_bit};
    assign trial_fits = ({1'b0, r_sq_v} >= trial);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_job_empty) begin
                    n_state = (i_job.count == '0) ? ST_FINISH : ST_DIV_MEAN;
                end
            end
            ST_DIV_MEAN:  n_state = ST_WAIT_MEAN;
            ST_WAIT_MEAN: begin
                if (div_rsp.done) begin
                    n_state = (r_job.count == CNT_W'(1)) ? ST_FINISH : ST_MUL1;
                end
            end
            ST_MUL1:      n_state = ST_MUL2;
            ST_MUL2:      n_state = ST_VAR;
            ST_VAR:       n_state = ST_DIV_VAR;
            ST_DIV_VAR:   n_state = ST_WAIT_VAR;
            ST_WAIT_VAR: begin
                if (div_rsp.done) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (r_sq_bit[0]) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_job_pop        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = DVD_W'(r_job.sum);
        div_req.divisor  = r_job.count;
        out_load         = 1'b0;
        case (r_state)
            ST_IDLE:     o_job_pop = !i_job_empty;
            ST_DIV_MEAN: div_req.start = 1'b1;
            ST_DIV_VAR: begin
                div_req.start    = 1'b1;
                div_req.dividend = {r_var, FRAC_SHIFT'(0)};
                div_req.divisor  = r_job.count - 1'b1;
            end
            ST_FINISH:   out_load = !r_out_valid || i_pop;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Arithmetic datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_job    <= i_job;
                r_mean   <= '0;
                r_sq_res <= '0;
            end
            ST_WAIT_MEAN: begin
                if (div_rsp.done) begin
                    r_mean <= div_rsp.quotient[VALUE_W-1:0];
                end
            end
            ST_MUL1: r_prod1 <= r_job.count * r_mean;
            ST_MUL2: r_prod2 <= r_mean * diff;
            ST_VAR:  r_var   <= r_job.sq_sum - r_prod2[SQ_W-1:0];
            ST_WAIT_VAR: begin
                if (div_rsp.done) begin
                    r_sq_v   <= div_rsp.quotient;
                    r_sq_res <= '0;
                    r_sq_bit <= DVD_W'(1) << ROOT_TOP;
                end
            end
            ST_SQRT: begin
                if (trial_fits) begin
                    r_sq_v   <= r_sq_v - trial[DVD_W-1:0];
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
            default: ;
        endcase
    end

    // Output register: one finished result waits here until popped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.valid_count <= r_job.count;
            r_out.mean_value  <= r_mean;
            r_out.min_value   <= no_valid ? '0 : r_job.min;
            r_out.max_value   <= no_valid ? '0 : r_job.max;
            r_out.std_dev_q8  <= (|r_sq_res[DVD_W-1:STD_W]) ? STD_MAX : r_sq_res[STD_W-1:0];
            r_out.no_valid    <= no_valid;
            r_out.overflowed  <= r_job.overflowed;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/range_filtered_statistics.sv =====
// Top level of the range-filtered statistics block: front end, job queue and back end.
// Depends on rfs_pkg, rfs_front, rfs_queue, rfs_back and rfs_divider.
//
//  Channel   Handshake           Payload
//  -------   -----------------   ------------------------------------------------------
//  input     push / full         i_sample_value, i_last_item
//  result    empty / pop         o_valid_count, o_mean_value, o_min_value, o_max_value,
//                                o_std_dev_q8, o_no_valid, o_overflowed
//  config    i_cfg_we            i_cfg_index, i_cfg_data (write only, no wait)
//
// The front end takes one beat per cycle; a beat is only refused while the job queue is full.
// A set with two or more valid values holds the back end while the shared divider
// runs 59 steps for the mean and 59 for the scaled variance, and the root takes 30 steps.
// A set with one valid value skips the variance and the root; one with none skips all steps.
// With two sets queued and one in the back end, full stays high until the back end frees
// a slot; a result that is not popped holds the back end in its final state.
// Reset is synchronous and active low; it restores the limits to 10 and 500.
`default_nettype none

module range_filtered_statistics
    import rfs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire t_cfg_idx           i_cfg_index,
    input  wire logic [VALUE_W-1:0] i_cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [VALUE_W-1:0] i_sample_value,
    input  wire logic               i_last_item,
    output logic                    empty,
    input  wire logic               pop,
    output logic [CNT_W-1:0]        o_valid_count,
    output logic [VALUE_W-1:0]      o_mean_value,
    output logic [VALUE_W-1:0]      o_min_value,
    output logic [VALUE_W-1:0]      o_max_value,
    output logic [STD_W-1:0]        o_std_dev_q8,
    output logic                    o_no_valid,
    output logic                    o_overflowed
);

    logic    accept;
    logic    job_push;
    t_job    job_in;
    t_job    job_head;
    logic    job_empty;
    logic    job_full;
    logic    job_pop;
    logic    result_valid;
    t_result result;

    assign accept = push && !job_full;
    assign full   = job_full;

    rfs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_sample_value (i_sample_value),
        .i_last_item    (i_last_item),
        .o_job_push     (job_push),
        .o_job          (job_in)
    );

    rfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_head  (job_head),
        .o_empty (job_empty),
        .o_full  (job_full)
    );

    rfs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (job_head),
        .i_job_empty    (job_empty),
        .o_job_pop      (job_pop),
        .i_pop          (pop),
        .o_result_valid (result_valid),
        .o_result       (result)
    );

    // Result beat fields.
    assign empty         = !result_valid;
    assign o_valid_count = result.valid_count;
    assign o_mean_value  = result.mean_value;
    assign o_min_value   = result.min_value;
    assign o_max_value   = result.max_value;
    assign o_std_dev_q8  = result.std_dev_q8;
    assign o_no_valid    = result.no_valid;
    assign o_overflowed  = result.overflowed;

endmodule

`default_nettype wire

// ===== hw/rtl/rfs_checker.sv =====
// Port-level checks for range_filtered_statistics, attached to it by a bind.
// Depends on rfs_pkg and the macros in assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rfs_checker
    import rfs_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               empty,
    input wire logic               pop,
    input wire logic [CNT_W-1:0]   o_valid_count,
    input wire logic [VALUE_W-1:0] o_mean_value,
    input wire logic [VALUE_W-1:0] o_min_value,
    input wire logic [VALUE_W-1:0] o_max_value,
    input wire logic [STD_W-1:0]   o_std_dev_q8,
    input wire logic               o_no_valid,
    input wire logic               o_overflowed
);

    logic [CNT_W+3*VALUE_W+STD_W+1:0] result_beat;
    logic                             stats_zero;
    logic                             mean_bounded;

    // All fields of the result beat, and the conditions checked on them.
    assign result_beat  = {o_valid_count, o_mean_value, o_min_value, o_max_value,
                           o_std_dev_q8, o_no_valid, o_overflowed};
    assign stats_zero   = (o_valid_count == '0) && (o_mean_value == '0)
                          && (o_min_value == '0) && (o_max_value == '0)
                          && (o_std_dev_q8 == '0);
    assign mean_bounded = (o_valid_count != '0) && (o_min_value <= o_mean_value)
                          && (o_mean_value <= o_max_value);

    // A waiting result stays until it is popped.
    `RFS_ASSERT(a_result_held, !empty && !pop |=> !empty)

    // A waiting result does not change its fields.
    `RFS_ASSERT(a_result_stable, !empty && !pop |=> $stable(result_beat))

    // An empty set reports zeros in every statistic.
    `RFS_ASSERT_IMPLY(a_empty_set_zero, !empty && o_no_valid, stats_zero)

    // For a non-empty set the mean lies between minimum and maximum.
    `RFS_ASSERT_IMPLY(a_mean_in_range, !empty && !o_no_valid, mean_bounded)

endmodule

bind range_filtered_statistics rfs_checker u_rfs_checker (.*);

`default_nettype wire
